// File: rtl/dvtd_pkg.sv
package dvtd_pkg;

   // Field widths of the two channels.
   localparam int DATA_W   = 8;
   localparam int PARENT_W = 16;
   localparam int STATUS_W = 3;
   localparam int SECS_W   = 38;

   // Internal widths of the calendar arithmetic.
   localparam int YEAR_W     = 14;
   localparam int FIELD_W    = 7;
   localparam int NUM_FIELDS = 5;
   localparam int FIELD_IDX_W = 3;
   localparam int DAYS_W     = 22;
   localparam int COUNT_W    = 4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_END      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TAG  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEN  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TIME = 3'd4;

   // Identifier and length octets.
   localparam logic [DATA_W-1:0] TAG_UTC      = 8'h17;
   localparam logic [DATA_W-1:0] TAG_GEN      = 8'h18;
   localparam logic [DATA_W-1:0] LEN_INDEF    = 8'h80;
   localparam logic [DATA_W-1:0] LEN_RESERVED = 8'hFF;
   localparam logic [6:0]        UTC_LEN      = 7'd13;
   localparam logic [6:0]        GEN_LEN      = 7'd15;
   localparam logic [COUNT_W-1:0] MAX_LEN_OCTETS = 4'd8;

   // Characters of the time string.
   localparam logic [DATA_W-1:0] CHAR_0 = 8'h30;
   localparam logic [DATA_W-1:0] CHAR_9 = 8'h39;
   localparam logic [DATA_W-1:0] CHAR_Z = 8'h5A;

   // Digit counts of the two forms.
   localparam logic [COUNT_W-1:0] UTC_YEAR_DIGITS = 4'd2;
   localparam logic [COUNT_W-1:0] GEN_YEAR_DIGITS = 4'd4;
   localparam logic [COUNT_W-1:0] FIELD_DIGITS    = 4'd10;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic                      start;
      logic                      dec_rem;
      logic                      clear_len;
      logic                      shift_len;
      logic                      clear_time;
      logic                      digit_year;
      logic                      digit_field;
      logic [FIELD_IDX_W-1:0]    field_idx;
      logic                      field_tens;
      logic                      fin_year;
      logic                      fin_div;
      logic                      fin_days;
      logic                      load_out;
      logic [STATUS_W-1:0]       out_code;
   } dp_cmd_type;

   // Decisions from the datapath to the sequencer.
   typedef struct packed {
      logic                parent_short;
      logic                len_reserved;
      logic                len_long;
      logic                len_over_parent;
      logic [COUNT_W-1:0]  len_octets;
      logic                short_size_bad;
      logic                tag_ok;
      logic                form_gen;
      logic                byte_zero;
      logic                long_small;
      logic                long_over;
      logic                is_digit;
      logic                is_z;
      logic                cal_bad;
   } dp_status_type;

   // Days in each month of a common year, January at index zero.
   function automatic logic [4:0] month_days(input logic [3:0] idx);
      logic [4:0] days;
      unique case (idx)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 5'd31;
         4'd1:                                      days = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:                   days = 5'd30;
         default:                                   days = 5'd0;
      endcase
      return days;
   endfunction

   // Days of a common year before the first of each month.
   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] days;
      unique case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// File: rtl/der_validity_time_decoder.sv
// Channel   Handshake              Contents
// req       req_valid/req_ready    one byte of the element, start mark, parent bytes left
// rsp       rsp_valid/rsp_ready    status, Unix seconds, GeneralizedTime flag
//
// Header and digit bytes are taken at one word per cycle while no result word waits on rsp_ready.
// After the final 'Z' four calendar steps follow in order (full year, divide by
// one hundred, day count, seconds multiply); the last loads the result word.
// A result word waiting on rsp_ready holds off further input words.
// Reset is synchronous and active high; the block is ready in the cycle after it.
module der_validity_time_decoder #(
   parameter int PARENT_LEN_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dvtd_pkg::DATA_W-1:0]         req_data_byte,
   input  logic                                req_start_req,
   input  logic [dvtd_pkg::PARENT_W-1:0]       req_parent_left,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dvtd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dvtd_pkg::SECS_W-1:0]         rsp_unix_seconds,
   output logic                                rsp_was_generalized
);

   dvtd_pkg::dp_cmd_type    dp_cmd;
   dvtd_pkg::dp_status_type dp_status;

   // Sequencer for the header, digits and calendar steps.
   dvtd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .rsp_ready     (rsp_ready),
      .dp_status     (dp_status),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .dp_cmd        (dp_cmd)
   );

   // Length checks, digit collection and epoch arithmetic.
   dvtd_datapath #(
      .PARENT_LEN_BITS (PARENT_LEN_BITS)
   ) u_datapath (
      .clock               (clock),
      .req_data_byte       (req_data_byte),
      .req_parent_left     (req_parent_left),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status),
      .rsp_status          (rsp_status),
      .rsp_unix_seconds    (rsp_unix_seconds),
      .rsp_was_generalized (rsp_was_generalized)
   );

endmodule

// File: rtl/dvtd_datapath.sv
module dvtd_datapath #(
   parameter int PARENT_LEN_BITS = 16
) (
   input  logic                                clock,
   input  logic [dvtd_pkg::DATA_W-1:0]         req_data_byte,
   input  logic [dvtd_pkg::PARENT_W-1:0]       req_parent_left,
   input  dvtd_pkg::dp_cmd_type                dp_cmd,
   output dvtd_pkg::dp_status_type             dp_status,
   output logic [dvtd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dvtd_pkg::SECS_W-1:0]         rsp_unix_seconds,
   output logic                                rsp_was_generalized
);

   localparam int RemBits = (PARENT_LEN_BITS < dvtd_pkg::PARENT_W) ?
                            PARENT_LEN_BITS : dvtd_pkg::PARENT_W;
   localparam int LenW      = 16;
   localparam int DivProdW  = 27;
   localparam int DivShift  = 19;
   localparam int QuotW     = DivProdW - DivShift;
   localparam int DaySecsW  = dvtd_pkg::DAYS_W + 17;
   localparam logic [12:0] Recip100 = 13'd5243;
   localparam logic [dvtd_pkg::YEAR_W-1:0] EpochYear = 14'd1970;
   localparam logic [dvtd_pkg::YEAR_W-1:0] UtcPivot  = 14'd50;
   localparam logic [dvtd_pkg::YEAR_W-1:0] Century20 = 14'd2000;
   localparam logic [dvtd_pkg::YEAR_W-1:0] Century19 = 14'd1900;
   localparam logic [dvtd_pkg::DAYS_W-1:0] LeapsBeforeEpoch = 22'd477;
   localparam int FieldMon = 0;
   localparam int FieldDay = 1;
   localparam int FieldHr  = 2;
   localparam int FieldMin = 3;
   localparam int FieldSec = 4;

   // Element header state.
   logic                       form_ff, form_in;
   logic                       tag_ff, tag_in;
   logic [RemBits-1:0]         rem_ff, rem_in;
   logic [LenW-1:0]            len_low_ff, len_low_in;
   logic                       len_big_ff, len_big_in;

   // Collected digits.
   logic [dvtd_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [dvtd_pkg::FIELD_W-1:0] field_ff [dvtd_pkg::NUM_FIELDS];

   // Calendar pipeline registers.
   logic [dvtd_pkg::YEAR_W-1:0]  year_full_ff, year_full_in;
   logic [DivProdW-1:0]          div_prod_ff, div_prod_in;
   logic [dvtd_pkg::DAYS_W-1:0]  yoff365_ff, yoff365_in;
   logic                         early_bad_ff, early_bad_in;
   logic [dvtd_pkg::DAYS_W-1:0]  days_ff, days_in;
   logic                         cal_bad_ff, cal_bad_in;

   // Result word.
   logic [dvtd_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [dvtd_pkg::SECS_W-1:0]   secs_ff, secs_in;
   logic                          gen_ff, gen_in;

   logic [RemBits-1:0]           rem_dec;
   logic [LenW-1:0]              rem_dec16;
   logic [LenW-1:0]              len_low_next;
   logic                         len_big_next;
   logic [3:0]                   digit;
   logic [dvtd_pkg::FIELD_W-1:0] mon, day, hr, mn, sc;
   logic [dvtd_pkg::YEAR_W-1:0]  ym1;
   logic [QuotW-1:0]             q100, q100p1;
   logic [dvtd_pkg::YEAR_W-1:0]  r100;
   logic                         leap;
   logic [dvtd_pkg::DAYS_W-1:0]  leaps;
   logic [3:0]                   mon_idx;
   logic [4:0]                   dim;
   logic [DaySecsW-1:0]          day_secs;
   logic [dvtd_pkg::SECS_W-1:0]  secs_total;

   // Byte decode and header compares.
   always_comb begin
      rem_dec      = rem_ff - RemBits'(rem_ff != '0);
      rem_dec16    = LenW'(rem_dec);
      len_low_next = {len_low_ff[7:0], req_data_byte};
      len_big_next = len_big_ff | (len_low_ff[LenW-1:8] != '0);
      digit        = 4'(req_data_byte - dvtd_pkg::CHAR_0);

      dp_status.parent_short    = req_parent_left[RemBits-1:0] < RemBits'(2);
      dp_status.len_reserved    = (req_data_byte == dvtd_pkg::LEN_INDEF) ||
                                  (req_data_byte == dvtd_pkg::LEN_RESERVED);
      dp_status.len_long        = req_data_byte[7];
      dp_status.len_over_parent = LenW'(req_data_byte[6:0]) > rem_dec16;
      dp_status.len_octets      = (req_data_byte[6:0] > 7'(dvtd_pkg::MAX_LEN_OCTETS)) ?
                                  dvtd_pkg::MAX_LEN_OCTETS + 4'd1 : req_data_byte[3:0];
      dp_status.short_size_bad  = req_data_byte[6:0] !=
                                  (form_ff ? dvtd_pkg::GEN_LEN : dvtd_pkg::UTC_LEN);
      dp_status.tag_ok          = tag_ff;
      dp_status.form_gen        = form_ff;
      dp_status.byte_zero       = req_data_byte == '0;
      dp_status.long_small      = !len_big_next && (len_low_next <= LenW'(127));
      dp_status.long_over       = len_big_next || (len_low_next > rem_dec16);
      dp_status.is_digit        = (req_data_byte >= dvtd_pkg::CHAR_0) &&
                                  (req_data_byte <= dvtd_pkg::CHAR_9);
      dp_status.is_z            = req_data_byte == dvtd_pkg::CHAR_Z;
      dp_status.cal_bad         = cal_bad_ff;
   end

   // Header registers: tag, parent budget and the long-form length.
   // The identifier byte itself is taken off the parent budget on start.
   always_comb begin
      form_in    = form_ff;
      tag_in     = tag_ff;
      rem_in     = rem_ff;
      len_low_in = len_low_ff;
      len_big_in = len_big_ff;
      if (dp_cmd.start) begin
         form_in = req_data_byte == dvtd_pkg::TAG_GEN;
         tag_in  = (req_data_byte == dvtd_pkg::TAG_UTC) ||
                   (req_data_byte == dvtd_pkg::TAG_GEN);
         rem_in  = req_parent_left[RemBits-1:0] - RemBits'(1);
      end else if (dp_cmd.dec_rem) begin
         rem_in = rem_dec;
      end
      if (dp_cmd.clear_len) begin
         len_low_in = '0;
         len_big_in = 1'b0;
      end else if (dp_cmd.shift_len) begin
         len_low_in = len_low_next;
         len_big_in = len_big_next;
      end
   end

   // The year is built most significant digit first.
   always_comb begin
      year_in = year_ff;
      if (dp_cmd.clear_time) begin
         year_in = '0;
      end else if (dp_cmd.digit_year) begin
         year_in = dvtd_pkg::YEAR_W'(year_ff * 14'd10) + dvtd_pkg::YEAR_W'(digit);
      end
   end

   assign mon = field_ff[FieldMon];
   assign day = field_ff[FieldDay];
   assign hr  = field_ff[FieldHr];
   assign mn  = field_ff[FieldMin];
   assign sc  = field_ff[FieldSec];

   // Calendar, first and second steps: full year, then divide-by-100 product, day offset and range checks.
   always_comb begin
      year_full_in = year_full_ff;
      div_prod_in  = div_prod_ff;
      yoff365_in   = yoff365_ff;
      early_bad_in = early_bad_ff;
      if (dp_cmd.fin_year) begin
         if (form_ff) begin
            year_full_in = year_ff;
         end else begin
            year_full_in = year_ff + ((year_ff < UtcPivot) ? Century20 : Century19);
         end
      end
      if (dp_cmd.fin_div) begin
         div_prod_in  = DivProdW'(ym1) * DivProdW'(Recip100);
         yoff365_in   = dvtd_pkg::DAYS_W'(year_full_ff - EpochYear) *
                        dvtd_pkg::DAYS_W'(365);
         early_bad_in = (year_full_ff < EpochYear) || (mon == '0) ||
                        (mon > 7'd12) || (hr > 7'd23) || (mn > 7'd59) || (sc > 7'd59);
      end
   end

   // Calendar, third step: leap rules and day count since the epoch.
   always_comb begin
      ym1     = year_full_ff - 14'd1;
      q100    = div_prod_ff[DivProdW-1:DivShift];
      q100p1  = q100 + QuotW'(1);
      r100    = ym1 - dvtd_pkg::YEAR_W'(dvtd_pkg::YEAR_W'(q100) * 14'd100);
      leap    = (ym1[1:0] == 2'b11) && ((r100 != 14'd99) || (q100p1[1:0] == 2'b00));
      leaps   = dvtd_pkg::DAYS_W'(ym1 >> 2) - dvtd_pkg::DAYS_W'(q100) +
                dvtd_pkg::DAYS_W'(q100 >> 2) - LeapsBeforeEpoch;
      mon_idx = mon[3:0] - 4'd1;
      dim     = dvtd_pkg::month_days(mon_idx) + 5'((mon == 7'd2) && leap);
      days_in    = days_ff;
      cal_bad_in = cal_bad_ff;
      if (dp_cmd.fin_days) begin
         days_in = yoff365_ff + leaps +
                   dvtd_pkg::DAYS_W'(dvtd_pkg::days_before_month(mon_idx)) +
                   dvtd_pkg::DAYS_W'(leap && (mon > 7'd2)) +
                   dvtd_pkg::DAYS_W'(day) - dvtd_pkg::DAYS_W'(1);
         cal_bad_in = early_bad_ff || (day == '0) || (day > 7'(dim));
      end
   end

   // Calendar, last step: seconds, loaded straight into the result word.
   always_comb begin
      day_secs   = DaySecsW'(days_ff) * DaySecsW'(86400);
      secs_total = dvtd_pkg::SECS_W'(day_secs) +
                   dvtd_pkg::SECS_W'(hr) * dvtd_pkg::SECS_W'(3600) +
                   dvtd_pkg::SECS_W'(mn) * dvtd_pkg::SECS_W'(60) +
                   dvtd_pkg::SECS_W'(sc);
      status_in = status_ff;
      secs_in   = secs_ff;
      gen_in    = gen_ff;
      if (dp_cmd.load_out) begin
         status_in = dp_cmd.out_code;
         if (dp_cmd.out_code == dvtd_pkg::STATUS_OK) begin
            secs_in = secs_total;
            gen_in  = form_ff;
         end else begin
            secs_in = '0;
            gen_in  = 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      form_ff      <= form_in;
      tag_ff       <= tag_in;
      rem_ff       <= rem_in;
      len_low_ff   <= len_low_in;
      len_big_ff   <= len_big_in;
      year_ff      <= year_in;
      year_full_ff <= year_full_in;
      div_prod_ff  <= div_prod_in;
      yoff365_ff   <= yoff365_in;
      early_bad_ff <= early_bad_in;
      days_ff      <= days_in;
      cal_bad_ff   <= cal_bad_in;
      status_ff    <= status_in;
      secs_ff      <= secs_in;
      gen_ff       <= gen_in;
   end

   // A tens digit overwrites its field, the units digit adds to it.
   always_ff @(posedge clock) begin
      if (dp_cmd.digit_field) begin
         if (dp_cmd.field_tens) begin
            field_ff[dp_cmd.field_idx] <= dvtd_pkg::FIELD_W'(digit) *
                                          dvtd_pkg::FIELD_W'(10);
         end else begin
            field_ff[dp_cmd.field_idx] <= field_ff[dp_cmd.field_idx] +
                                          dvtd_pkg::FIELD_W'(digit);
         end
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_unix_seconds    = secs_ff;
   assign rsp_was_generalized = gen_ff;

endmodule

// File: rtl/dvtd_ctrl.sv
module dvtd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_start_req,
   input  logic                    rsp_ready,
   input  dvtd_pkg::dp_status_type dp_status,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output dvtd_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_LEN      = 8'b0000_0010,
      ST_LONG     = 8'b0000_0100,
      ST_BODY     = 8'b0000_1000,
      ST_FIN_YEAR = 8'b0001_0000,
      ST_FIN_DIV  = 8'b0010_0000,
      ST_FIN_DAYS = 8'b0100_0000,
      ST_FIN_SECS = 8'b1000_0000
   } state_type;

   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dvtd_pkg::COUNT_W-1:0]    octets_ff, octets_in;
   logic                            first_ff, first_in;
   logic [dvtd_pkg::COUNT_W-1:0]    digit_ff, digit_in;

   logic                            byte_state;
   logic                            out_free;
   logic                            accept;
   logic [dvtd_pkg::COUNT_W-1:0]    year_digits;
   logic [dvtd_pkg::COUNT_W-1:0]    digit_limit;
   logic [dvtd_pkg::COUNT_W-1:0]    field_pos;

   // Words are taken only in the byte states and while the result slot can be refilled.
   always_comb begin
      byte_state = (state_ff == ST_IDLE) || (state_ff == ST_LEN) ||
                   (state_ff == ST_LONG) || (state_ff == ST_BODY);
      out_free   = !rsp_valid_ff || rsp_ready;
      req_ready  = byte_state && out_free;
      accept     = req_valid && req_ready;
   end

   // Digit position within the time string.
   always_comb begin
      year_digits = dp_status.form_gen ? dvtd_pkg::GEN_YEAR_DIGITS :
                                         dvtd_pkg::UTC_YEAR_DIGITS;
      digit_limit = year_digits + dvtd_pkg::FIELD_DIGITS;
      field_pos   = digit_ff - year_digits;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      octets_in = octets_ff;
      first_in  = first_ff;
      digit_in  = digit_ff;
      dp_cmd    = '0;
      dp_cmd.field_idx  = field_pos[dvtd_pkg::FIELD_IDX_W:1];
      dp_cmd.field_tens = !field_pos[0];
      dp_cmd.out_code   = dvtd_pkg::STATUS_OK;

      if (accept && req_start_req) begin
         dp_cmd.start = 1'b1;
         if (dp_status.parent_short) begin
            dp_cmd.load_out = 1'b1;
            dp_cmd.out_code = dvtd_pkg::STATUS_END;
            state_in        = ST_IDLE;
         end else begin
            state_in = ST_LEN;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               state_in = ST_IDLE;
            end
            ST_LEN: begin
               if (accept) begin
                  dp_cmd.dec_rem = 1'b1;
                  priority if (dp_status.len_reserved) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_BAD_LEN;
                     state_in        = ST_IDLE;
                  end else if (dp_status.len_over_parent) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_END;
                     state_in        = ST_IDLE;
                  end else if (dp_status.len_long) begin
                     dp_cmd.clear_len = 1'b1;
                     octets_in        = dp_status.len_octets;
                     first_in         = 1'b1;
                     state_in         = ST_LONG;
                  end else if (!dp_status.tag_ok) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_BAD_TAG;
                     state_in        = ST_IDLE;
                  end else if (dp_status.short_size_bad) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_BAD_TIME;
                     state_in        = ST_IDLE;
                  end else begin
                     dp_cmd.clear_time = 1'b1;
                     digit_in          = '0;
                     state_in          = ST_BODY;
                  end
               end
            end
            ST_LONG: begin
               if (accept) begin
                  dp_cmd.dec_rem = 1'b1;
                  priority if (first_ff && dp_status.byte_zero) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_BAD_LEN;
                     state_in        = ST_IDLE;
                  end else if (first_ff && (octets_ff > dvtd_pkg::MAX_LEN_OCTETS)) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_END;
                     state_in        = ST_IDLE;
                  end else begin
                     dp_cmd.shift_len = 1'b1;
                     first_in         = 1'b0;
                     octets_in        = octets_ff - 4'd1;
                     // On the last length octet, a long form can never give a valid size.
                     if (octets_ff == 4'd1) begin
                        dp_cmd.load_out = 1'b1;
                        state_in        = ST_IDLE;
                        priority if (dp_status.long_small) begin
                           dp_cmd.out_code = dvtd_pkg::STATUS_BAD_LEN;
                        end else if (dp_status.long_over) begin
                           dp_cmd.out_code = dvtd_pkg::STATUS_END;
                        end else if (!dp_status.tag_ok) begin
                           dp_cmd.out_code = dvtd_pkg::STATUS_BAD_TAG;
                        end else begin
                           dp_cmd.out_code = dvtd_pkg::STATUS_BAD_TIME;
                        end
                     end
                  end
               end
            end
            ST_BODY: begin
               if (accept) begin
                  if (digit_ff < digit_limit) begin
                     if (!dp_status.is_digit) begin
                        dp_cmd.load_out = 1'b1;
                        dp_cmd.out_code = dvtd_pkg::STATUS_BAD_TIME;
                        state_in        = ST_IDLE;
                     end else begin
                        dp_cmd.digit_year  = digit_ff < year_digits;
                        dp_cmd.digit_field = digit_ff >= year_digits;
                        digit_in           = digit_ff + 4'd1;
                     end
                  end else if (!dp_status.is_z) begin
                     dp_cmd.load_out = 1'b1;
                     dp_cmd.out_code = dvtd_pkg::STATUS_BAD_TIME;
                     state_in        = ST_IDLE;
                  end else begin
                     state_in = ST_FIN_YEAR;
                  end
               end
            end
            ST_FIN_YEAR: begin
               dp_cmd.fin_year = 1'b1;
               state_in        = ST_FIN_DIV;
            end
            ST_FIN_DIV: begin
               dp_cmd.fin_div = 1'b1;
               state_in       = ST_FIN_DAYS;
            end
            ST_FIN_DAYS: begin
               dp_cmd.fin_days = 1'b1;
               state_in        = ST_FIN_SECS;
            end
            ST_FIN_SECS: begin
               if (out_free) begin
                  dp_cmd.load_out = 1'b1;
                  dp_cmd.out_code = dp_status.cal_bad ? dvtd_pkg::STATUS_BAD_TIME :
                                                        dvtd_pkg::STATUS_OK;
                  state_in        = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // The result slot fills on a load and empties when the word is taken.
   always_comb begin
      rsp_valid_in = dp_cmd.load_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         octets_ff    <= '0;
         first_ff     <= 1'b0;
         digit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         octets_ff    <= octets_in;
         first_ff     <= first_in;
         digit_ff     <= digit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result slot overwritten");

   // The long-form octet count stays within one to nine.
   a_octets_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LONG) |-> ((octets_ff != 4'd0) && (octets_ff <= 4'd9)))
      else $error("long-form octet count out of range");

   // The digit index never runs past the final character.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BODY) |-> (digit_ff <= 4'd14))
      else $error("digit index out of range");

   // A start word with enough parent bytes always moves on to the length octet.
   a_start_to_len: assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_req && !dp_status.parent_short) |=> (state_ff == ST_LEN))
      else $error("start word did not enter length decode");
`endif

endmodule
